@@ src/mmf_pkg.sv @@
// shared types and constants of the moving median filter
`default_nettype none

package mmf_pkg;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_W      = 5;

    // register map, word index taken from paddr above the byte offset
    localparam logic REG_WINDOW_LEN = 1'b0;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 5'd15;

    // control broadcast from the top level to every cell of the sorted row
    typedef struct packed {
        logic load;     // a sample beat is taken in this cycle
        logic restart;  // window empties before the new sample goes in
        logic full;     // window holds window_len samples, oldest leaves
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ src/moving_median_filter.sv @@
// moving median filter top level: sorted cell row, control and register port
//
// Input channel i_valid / o_ready carries i_sample and i_block_start; output
// channel o_valid / i_ready carries o_median. Every accepted sample beat gives
// exactly one result beat: the median of the newest window_len samples seen
// since the last block start (fewer while the window fills).
// Samples live in a row of MAX_WINDOW cells kept in ascending order. In the
// cycle a beat is taken, the row drops the oldest entry once full, makes room
// for the new sample and ages each entry in one neighbour-to-neighbour step.
// Throughput is one beat per cycle unless i_ready stalls the output. After the
// edge that accepts a sample, its middle pair is picked out of the row into a
// register, then averaged into the output register that drives o_median.
// When a result beat waits with i_ready low the whole pipe holds, the result
// stays on o_median and o_ready drops; o_ready is high whenever the output
// register is empty.
// Reset empties the window and the pipe and sets window_len to 15. Writing
// window_len over the register port (byte address 0) also empties the window.
// Values 0 and above MAX_WINDOW act as 1 and MAX_WINDOW.
`default_nettype none

module moving_median_filter #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 19
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // sample beats
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire signed [SAMPLE_BITS-1:0]       i_sample,
    input  wire                                i_block_start,
    // result beats
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_median,
    // register port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire        [mmf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire        [mmf_pkg::APB_DATA_W-1:0] pwdata,
    output logic       [mmf_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);
    import mmf_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [CFG_W-1:0] r_len;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CNT_W-1:0] len_eff;
    logic [AGE_W-1:0] age_last;
    logic [AGE_W-1:0] half;
    logic [AGE_W-1:0] lo_idx;
    logic             odd;
    logic             full;
    logic             adv;
    logic             accept;
    logic             cfg_wr;
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    t_cell_ctl        ctl;

    logic signed [SAMPLE_BITS-1:0]           cell_value [MAX_WINDOW];
    logic        [AGE_W-1:0]                 cell_age   [MAX_WINDOW];
    logic                                    cell_up    [MAX_WINDOW];
    logic                                    cell_down  [MAX_WINDOW];
    logic                                    cell_evb   [MAX_WINDOW];
    logic        [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] lo_vals;
    logic        [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] hi_vals;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LEN);

    always_comb begin
        if (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LEN) begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_len};
        end else begin
            prdata = '0;
        end
    end

    // effective window length
    always_comb begin
        if (r_len == '0) begin
            len_eff = CNT_W'(1);
        end else if (int'(r_len) > MAX_WINDOW) begin
            len_eff = CNT_W'(MAX_WINDOW);
        end else begin
            len_eff = CNT_W'(r_len);
        end
        age_last = AGE_W'(len_eff - 1'b1);
    end

    // handshake and pipe advance
    assign adv     = !r_v3 || i_ready;
    assign o_ready = adv;
    assign accept  = i_valid && adv;
    assign o_valid = r_v3;

    // fill count after the new sample
    always_comb begin
        full = (r_fill == len_eff);
        if (i_block_start) begin
            n_fill = CNT_W'(1);
        end else if (full) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + 1'b1;
        end
        ctl.load    = accept;
        ctl.restart = i_block_start;
        ctl.full    = full && !i_block_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= WINDOW_LEN_RESET;
            r_fill <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_len  <= pwdata[CFG_W-1:0];
                r_fill <= '0;
            end else if (accept) begin
                r_fill <= n_fill;
            end
            if (adv) begin
                r_v1 <= accept;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    // middle pair positions for the count now held in the row
    always_comb begin
        half   = AGE_W'(r_fill >> 1);
        odd    = r_fill[0];
        lo_idx = odd ? half : half - 1'b1;
    end

    // sorted row of cells
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] left_value;
        logic        [AGE_W-1:0]       left_age;
        logic                          left_up;
        logic                          left_evb;
        logic signed [SAMPLE_BITS-1:0] right_value;
        logic        [AGE_W-1:0]       right_age;
        logic                          right_down;

        if (g == 0) begin : g_first
            assign left_value = '0;
            assign left_age   = '0;
            assign left_up    = 1'b0;
            assign left_evb   = 1'b0;
        end else begin : g_inner_l
            assign left_value = cell_value[g-1];
            assign left_age   = cell_age[g-1];
            assign left_up    = cell_up[g-1];
            assign left_evb   = cell_evb[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_last
            assign right_value = '0;
            assign right_age   = '0;
            assign right_down  = 1'b0;
        end else begin : g_inner_r
            assign right_value = cell_value[g+1];
            assign right_age   = cell_age[g+1];
            assign right_down  = cell_down[g+1];
        end

        mmf_cell #(
            .IDX    (g),
            .DATA_W (SAMPLE_BITS),
            .AGE_W  (AGE_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_sample      (i_sample),
            .i_fill        (r_fill),
            .i_age_last    (age_last),
            .i_lo_idx      (lo_idx),
            .i_hi_idx      (half),
            .i_left_value  (left_value),
            .i_left_age    (left_age),
            .i_left_up     (left_up),
            .i_right_value (right_value),
            .i_right_age   (right_age),
            .i_right_down  (right_down),
            .i_evb         (left_evb),
            .o_value       (cell_value[g]),
            .o_age         (cell_age[g]),
            .o_up          (cell_up[g]),
            .o_down        (cell_down[g]),
            .o_evb         (cell_evb[g]),
            .o_lo_value    (lo_vals[g]),
            .o_hi_value    (hi_vals[g])
        );
    end

    // middle pair and average
    mmf_median #(
        .DATA_W (SAMPLE_BITS),
        .N      (MAX_WINDOW)
    ) u_median (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_odd     (odd),
        .i_lo_vals (lo_vals),
        .i_hi_vals (hi_vals),
        .o_median  (o_median)
    );

endmodule

`default_nettype wire

@@ src/mmf_cell.sv @@
// one cell of the sorted sample row: holds a value and its age
`default_nettype none

module mmf_cell #(
    parameter int IDX    = 0,
    parameter int DATA_W = 19,
    parameter int AGE_W  = 4,
    parameter int CNT_W  = 5
) (
    input  wire                      i_clk,
    input  wire mmf_pkg::t_cell_ctl  i_ctl,
    input  wire signed [DATA_W-1:0]  i_sample,
    input  wire        [CNT_W-1:0]   i_fill,
    input  wire        [AGE_W-1:0]   i_age_last,
    input  wire        [AGE_W-1:0]   i_lo_idx,
    input  wire        [AGE_W-1:0]   i_hi_idx,
    // lower neighbour
    input  wire signed [DATA_W-1:0]  i_left_value,
    input  wire        [AGE_W-1:0]   i_left_age,
    input  wire                      i_left_up,
    // upper neighbour
    input  wire signed [DATA_W-1:0]  i_right_value,
    input  wire        [AGE_W-1:0]   i_right_age,
    input  wire                      i_right_down,
    // an eviction happened in a lower cell
    input  wire                      i_evb,
    output logic signed [DATA_W-1:0] o_value,
    output logic        [AGE_W-1:0]  o_age,
    output logic                     o_up,
    output logic                     o_down,
    output logic                     o_evb,
    output logic signed [DATA_W-1:0] o_lo_value,
    output logic signed [DATA_W-1:0] o_hi_value
);
    import mmf_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic        [AGE_W-1:0]  r_age;
    logic signed [DATA_W-1:0] n_value;
    logic        [AGE_W-1:0]  n_age;
    logic                     occ;
    logic                     ev;
    logic                     kept;
    logic                     le;
    logic                     stay;

    // local view of the row: occupied, leaving, below the new sample
    always_comb begin
        occ  = (CNT_W'(IDX) < i_fill) && !i_ctl.restart;
        ev   = occ && i_ctl.full && (r_age == i_age_last);
        kept = occ && !ev;
        le   = (r_value <= i_sample);
        stay = kept && (le ^ i_evb);
    end

    // a kept entry moves up past the new sample, down past the evicted one
    assign o_evb  = i_evb | ev;
    assign o_up   = kept && !le && !i_evb;
    assign o_down = kept && le && i_evb;

    // next content: own entry, a neighbour's entry or the new sample
    always_comb begin
        if (stay) begin
            n_value = r_value;
            n_age   = r_age + 1'b1;
        end else if (i_left_up) begin
            n_value = i_left_value;
            n_age   = i_left_age + 1'b1;
        end else if (i_right_down) begin
            n_value = i_right_value;
            n_age   = i_right_age + 1'b1;
        end else begin
            n_value = i_sample;
            n_age   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_value = r_value;
    assign o_age   = r_age;

    // middle pair taps, zero unless this cell is selected
    assign o_lo_value = (AGE_W'(IDX) == i_lo_idx) ? r_value : '0;
    assign o_hi_value = (AGE_W'(IDX) == i_hi_idx) ? r_value : '0;

endmodule

`default_nettype wire

@@ src/mmf_median.sv @@
// middle pair collection and averaging stages
`default_nettype none

module mmf_median #(
    parameter int DATA_W = 19,
    parameter int N      = 16
) (
    input  wire                             i_clk,
    input  wire                             i_adv,
    input  wire                             i_odd,
    input  wire        [N-1:0][DATA_W-1:0]  i_lo_vals,
    input  wire        [N-1:0][DATA_W-1:0]  i_hi_vals,
    output logic signed [DATA_W-1:0]        o_median
);
    import mmf_pkg::*;

    logic        [DATA_W-1:0] lo_or;
    logic        [DATA_W-1:0] hi_or;
    logic signed [DATA_W-1:0] r_lo;
    logic signed [DATA_W-1:0] r_hi;
    logic                     r_odd;
    logic signed [DATA_W:0]   sum;
    logic signed [DATA_W:0]   sum_adj;
    logic signed [DATA_W-1:0] n_median;
    logic signed [DATA_W-1:0] r_median;

    // only one cell drives each tap, so an or over the row selects it
    always_comb begin
        lo_or = '0;
        hi_or = '0;
        for (int k = 0; k < N; k++) begin
            lo_or = lo_or | i_lo_vals[k];
            hi_or = hi_or | i_hi_vals[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lo  <= signed'(lo_or);
            r_hi  <= signed'(hi_or);
            r_odd <= i_odd;
        end
    end

    // even count: halve the pair sum, rounding toward zero
    always_comb begin
        sum      = {r_lo[DATA_W-1], r_lo} + {r_hi[DATA_W-1], r_hi};
        sum_adj  = sum + {{DATA_W{1'b0}}, sum[DATA_W]};
        n_median = r_odd ? r_hi : sum_adj[DATA_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_median <= n_median;
        end
    end

    assign o_median = r_median;

endmodule

`default_nettype wire

@@ src/mmf_checker.sv @@
// port level checks of the moving median filter, bound to the top level
`default_nettype none

module mmf_checker #(
    parameter int SAMPLE_BITS = 19
) (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_valid,
    input wire                                  o_ready,
    input wire signed [SAMPLE_BITS-1:0]         i_sample,
    input wire                                  i_block_start,
    input wire                                  o_valid,
    input wire                                  i_ready,
    input wire signed [SAMPLE_BITS-1:0]         o_median,
    input wire                                  psel,
    input wire                                  penable,
    input wire                                  pwrite,
    input wire        [mmf_pkg::APB_ADDR_W-1:0] paddr,
    input wire        [mmf_pkg::APB_DATA_W-1:0] pwdata,
    input wire        [mmf_pkg::APB_DATA_W-1:0] prdata,
    input wire                                  pready
);
    import mmf_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_median))
        else $error("result beat changed while stalled");

    // an empty output register never blocks the sample side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("sample side stalled with empty output");

    // first sample of a block comes back as its own median
    a_block_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_block_start) ##1 o_ready ##1 o_ready
        |=> o_valid && (o_median == $past(i_sample, 3)))
        else $error("block start median differs from its sample");

    // window length reads back what was written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready
        && (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LEN)
        |=> (prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
            || (paddr[APB_ADDR_W-1:2] != REG_WINDOW_LEN))
        else $error("window length readback mismatch");

endmodule

bind moving_median_filter mmf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mmf_checker (.*);

`default_nettype wire
